@@ rtl/core/lsepg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsepg_pkg
// Types, register codes, effect codes and a sine table of the pixel generator.
// ----------------------------------------------------------------------------
package lsepg_pkg;

  localparam int LED_COUNT_DEF = 128;

  // register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_BASE   = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_PARAMS = 3'd3;
  localparam logic [2:0] REG_START  = 3'd4;
  localparam logic [2:0] REG_END    = 3'd5;

  // effect codes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_SOLID   = 3'd1;
  localparam logic [2:0] MODE_FADE    = 3'd2;
  localparam logic [2:0] MODE_BREATHE = 3'd3;
  localparam logic [2:0] MODE_CHASE   = 3'd4;
  localparam logic [2:0] MODE_COMET   = 3'd5;

  typedef struct packed {
    logic [7:0]  pixel_index;
    logic [31:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_t;

  // side data riding along the dividers
  typedef struct packed {
    logic       active;
    logic [7:0] rel;
    logic [7:0] idx;
  } d1_side_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  rel;
    logic [15:0] t;
  } d3_side_t;

  typedef struct packed {
    logic       active;
    logic [7:0] rel;
    logic [8:0] rem;
  } d2_side_t;

  // static settings handed to the colour stages
  typedef struct packed {
    logic [2:0]  mode;
    logic [23:0] base;
    logic [31:0] params;
    logic [7:0]  mn;
    logic [7:0]  len;
  } eff_cfg_t;

  localparam logic [7:0] SINE_ROM [256] = '{
    8'd128,8'd131,8'd134,8'd137,8'd140,8'd143,8'd146,8'd149,
    8'd152,8'd155,8'd158,8'd162,8'd165,8'd167,8'd170,8'd173,
    8'd176,8'd179,8'd182,8'd185,8'd188,8'd190,8'd193,8'd196,
    8'd198,8'd201,8'd203,8'd206,8'd208,8'd211,8'd213,8'd215,
    8'd218,8'd220,8'd222,8'd224,8'd226,8'd228,8'd230,8'd232,
    8'd234,8'd235,8'd237,8'd239,8'd240,8'd242,8'd243,8'd244,
    8'd246,8'd247,8'd248,8'd249,8'd250,8'd251,8'd252,8'd253,
    8'd253,8'd254,8'd254,8'd255,8'd255,8'd255,8'd255,8'd255,
    8'd255,8'd255,8'd255,8'd255,8'd255,8'd254,8'd254,8'd253,
    8'd253,8'd252,8'd251,8'd250,8'd249,8'd248,8'd247,8'd246,
    8'd244,8'd243,8'd242,8'd240,8'd239,8'd237,8'd235,8'd234,
    8'd232,8'd230,8'd228,8'd226,8'd224,8'd222,8'd220,8'd218,
    8'd215,8'd213,8'd211,8'd208,8'd206,8'd203,8'd201,8'd198,
    8'd196,8'd193,8'd190,8'd188,8'd185,8'd182,8'd179,8'd176,
    8'd173,8'd170,8'd167,8'd165,8'd162,8'd158,8'd155,8'd152,
    8'd149,8'd146,8'd143,8'd140,8'd137,8'd134,8'd131,8'd128,
    8'd124,8'd121,8'd118,8'd115,8'd112,8'd109,8'd106,8'd103,
    8'd100,8'd97, 8'd94, 8'd90, 8'd87, 8'd85, 8'd82, 8'd79,
    8'd76, 8'd73, 8'd70, 8'd67, 8'd64, 8'd62, 8'd59, 8'd56,
    8'd54, 8'd51, 8'd49, 8'd46, 8'd44, 8'd41, 8'd39, 8'd37,
    8'd34, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24, 8'd22, 8'd20,
    8'd18, 8'd17, 8'd15, 8'd13, 8'd12, 8'd10, 8'd9,  8'd8,
    8'd6,  8'd5,  8'd4,  8'd3,  8'd2,  8'd1,  8'd1,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
    8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd1,  8'd1,  8'd2,
    8'd2,  8'd3,  8'd4,  8'd5,  8'd6,  8'd7,  8'd8,  8'd9,
    8'd11, 8'd12, 8'd13, 8'd15, 8'd16, 8'd18, 8'd20, 8'd21,
    8'd23, 8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd35, 8'd37,
    8'd40, 8'd42, 8'd44, 8'd47, 8'd49, 8'd52, 8'd54, 8'd57,
    8'd59, 8'd62, 8'd65, 8'd67, 8'd70, 8'd73, 8'd76, 8'd79,
    8'd82, 8'd85, 8'd88, 8'd90, 8'd93, 8'd97, 8'd100,8'd103,
    8'd106,8'd109,8'd112,8'd115,8'd118,8'd121,8'd124,8'd128
  };

  // floor(x / 255) for any 16-bit x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lsepg_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsepg_div
// Pipelined restoring divider, one quotient bit per stage, side data in step.
// The top NW-QW dividend bits must already be below the divisor. The user must
// hold the divisor static while items are in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module lsepg_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quot,
  output logic [DW-1:0]      out_rem,
  output logic [SW-1:0]      out_side
);

  logic          v_r    [0:QW];
  logic [DW-1:0] rem_r  [0:QW];
  logic [QW-1:0] w_r    [0:QW];
  logic [SW-1:0] side_r [0:QW];

  // stage zero: the upper dividend bits seed the partial remainder
  assign v_r[0]    = in_valid;
  assign rem_r[0]  = DW'(in_num >> QW);
  assign w_r[0]    = in_num[QW-1:0];
  assign side_r[0] = in_side;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    // one compare and subtract per stage
    always_comb begin
      trial   = {rem_r[s], w_r[s][QW-1]};
      ge      = trial >= {1'b0, in_den};
      rem_nxt = ge ? DW'(trial - {1'b0, in_den}) : trial[DW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= rem_nxt;
        w_r[s+1]    <= {w_r[s][QW-2:0], ge};
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quot  = w_r[QW];
  assign out_rem   = rem_r[QW];
  assign out_side  = side_r[QW];

endmodule
`default_nettype wire

@@ rtl/core/lsepg_effect.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsepg_effect
// Three colour stages: table lookup and blend products, scaling by 255,
// brightness scaling and effect selection into the output register.
// ----------------------------------------------------------------------------
module lsepg_effect (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire lsepg_pkg::eff_cfg_t cfg,
  input  wire logic                in_valid,
  input  wire logic [7:0]          in_frac,
  input  wire lsepg_pkg::d2_side_t in_side,
  output logic                     out_valid,
  output lsepg_pkg::out_t          out_data
);
  import lsepg_pkg::*;

  logic [7:0] r, g, b, pa, pb, pc;
  assign r  = cfg.base[23:16];
  assign g  = cfg.base[15:8];
  assign b  = cfg.base[7:0];
  assign pa = cfg.params[31:24];
  assign pb = cfg.params[23:16];
  assign pc = cfg.params[15:8];

  // stage 1: sine lookup, fade products, position hit
  logic        v1_r, act1_r, hit1_r;
  logic [7:0]  sv1_r;
  logic [15:0] fr1_r, fg1_r, fb1_r;
  logic        hit_nxt;
  logic [7:0]  pos;
  logic [7:0]  nf;

  always_comb begin
    nf  = 8'd255 - in_frac;
    pos = (pc == 8'd2 || pc == 8'd3) ? 8'(cfg.len - 8'd1 - in_side.rem[7:0])
                                     : in_side.rem[7:0];
    unique case (cfg.mode)
      MODE_CHASE: hit_nxt = (in_side.rem == 9'd0);
      MODE_COMET: hit_nxt = (in_side.rem < {1'b0, cfg.len}) && (pos == in_side.rel);
      default:    hit_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act1_r <= in_side.active;
      hit1_r <= hit_nxt;
      sv1_r  <= SINE_ROM[in_frac];
      fr1_r  <= 16'(r) * 16'(nf) + 16'(pa) * 16'(in_frac);
      fg1_r  <= 16'(g) * 16'(nf) + 16'(pb) * 16'(in_frac);
      fb1_r  <= 16'(b) * 16'(nf) + 16'(pc) * 16'(in_frac);
    end
  end

  // stage 2: fade scaling, breathe brightness
  logic       v2_r, act2_r, hit2_r;
  logic [7:0] fr2_r, fg2_r, fb2_r, bri2_r;
  logic [7:0] span;
  assign span = 8'd255 - cfg.mn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      act2_r <= act1_r;
      hit2_r <= hit1_r;
      fr2_r  <= div255(fr1_r);
      fg2_r  <= div255(fg1_r);
      fb2_r  <= div255(fb1_r);
      bri2_r <= cfg.mn + div255(16'(span) * 16'(sv1_r));
    end
  end

  // stage 3: choose the colour of the effect
  logic       v3_r;
  out_t       out_r;
  out_t       out_nxt;

  always_comb begin
    out_nxt = '0;
    if (act2_r) begin
      unique case (cfg.mode)
        MODE_SOLID: out_nxt = {r, g, b};
        MODE_FADE:  out_nxt = {fr2_r, fg2_r, fb2_r};
        MODE_BREATHE: begin
          out_nxt = {div255(16'(r) * 16'(bri2_r)), div255(16'(g) * 16'(bri2_r)),
                     div255(16'(b) * 16'(bri2_r))};
        end
        MODE_CHASE, MODE_COMET: out_nxt = hit2_r ? {r, g, b} : '0;
        default:    out_nxt = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ rtl/core/led_strip_effect_pixel_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_effect_pixel_generator
// Per-pixel colour for a configured LED strip effect over an LED range.
// ----------------------------------------------------------------------------
// One pixel is taken in every cycle unless the output stalls. It passes one
// front stage, 32 stages dividing time by the period, 33 stages for the chase
// or comet modulo, 8 stages for the fade or breathe fraction and three colour
// stages. Unstalled throughput is one pixel per cycle, set by the one-bit-per-
// stage divider pipelines. A stall at the output freezes the whole pipe; a
// one-entry skid buffer keeps the input side registered. The user must write
// registers only while no pixel is in flight; the block does not enforce it.
module led_strip_effect_pixel_generator #(
  parameter int LED_COUNT = lsepg_pkg::LED_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire lsepg_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output lsepg_pkg::out_t      out_data,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [4:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import lsepg_pkg::*;

  // configuration registers
  logic [2:0]  mode_r;
  logic [23:0] base_r;
  logic [15:0] period_r;
  logic [31:0] params_r;
  logic [7:0]  start_r, end_r;
  logic        wr;
  logic [2:0]  widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign widx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_OFF;
      base_r   <= '0;
      period_r <= '0;
      params_r <= '0;
      start_r  <= '0;
      end_r    <= 8'd127;
    end else if (wr) begin
      unique case (widx)
        REG_MODE:   mode_r   <= pwdata[2:0];
        REG_BASE:   base_r   <= pwdata[23:0];
        REG_PERIOD: period_r <= pwdata[15:0];
        REG_PARAMS: params_r <= pwdata;
        REG_START:  start_r  <= pwdata[7:0];
        REG_END:    end_r    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_MODE:   prdata = {29'd0, mode_r};
      REG_BASE:   prdata = {8'd0, base_r};
      REG_PERIOD: prdata = {16'd0, period_r};
      REG_PARAMS: prdata = params_r;
      REG_START:  prdata = {24'd0, start_r};
      REG_END:    prdata = {24'd0, end_r};
      default:    prdata = '0;
    endcase
  end

  // values derived from the static settings
  logic [7:0]  end_c, len, pa, pc;
  logic [15:0] per;
  logic        rev, rng_ok;
  logic [8:0]  sp, tail, cmod;
  logic [7:0]  pct;
  logic [14:0] pct255;
  logic [7:0]  mn_r;
  logic [28:0] mn_prod;

  assign pa     = params_r[31:24];
  assign pc     = params_r[15:8];
  assign end_c  = (end_r >= 8'(LED_COUNT)) ? 8'(LED_COUNT - 1) : end_r;
  assign rng_ok = (start_r != 8'hFF) && (end_r >= start_r) && (start_r <= end_c);
  assign len    = 8'(end_c - start_r + 8'd1);
  assign per    = (period_r == 16'd0) ? 16'd1 : period_r;
  assign rev    = (pc == 8'd2) || (pc == 8'd3);
  assign sp     = (pa < 8'd2) ? 9'd3 : {1'b0, pa};
  assign tail   = (pa == 8'd0) ? 9'd5 : {1'b0, pa};
  assign cmod   = (mode_r == MODE_CHASE) ? sp : 9'({1'b0, len} + tail);
  assign pct    = (pa > 8'd100) ? 8'd100 : pa;
  assign pct255 = 15'({pct, 8'd0} - {8'd0, pct});
  // minimum brightness, divide by 100 through a reciprocal
  assign mn_prod = 29'(pct255) * 29'd5243;

  always_ff @(posedge clk) begin
    mn_r <= mn_prod[26:19];
  end

  // pipeline advance and input skid
  logic adv;
  logic skid_v_r;
  in_t  skid_r;
  in_t  sel;
  logic sel_v;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = skid_v_r;
  assign sel      = skid_v_r ? skid_r : in_data;
  assign sel_v    = skid_v_r || in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_valid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && !skid_v_r) begin
      skid_r <= in_data;
    end
  end

  // front stage: range test and relative position
  logic        fv_r;
  logic [31:0] fel_r;
  d1_side_t    fside_r;
  d1_side_t    fside_nxt;

  always_comb begin
    fside_nxt.active = rng_ok && (sel.pixel_index >= start_r) &&
                       (sel.pixel_index <= end_c);
    fside_nxt.rel    = 8'(sel.pixel_index - start_r);
    fside_nxt.idx    = rev ? 8'(len - 8'd1 - fside_nxt.rel) : fside_nxt.rel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (adv) begin
      fv_r <= sel_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fel_r   <= sel.elapsed_ms;
      fside_r <= fside_nxt;
    end
  end

  // elapsed time over the period
  logic        d1_v;
  logic [31:0] d1_q;
  logic [15:0] d1_t;
  d1_side_t    d1_side;

  lsepg_div #(.NW(32), .DW(16), .QW(32), .SW($bits(d1_side_t))) u_div_time (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (fv_r),
    .in_num   (fel_r),
    .in_den   (per),
    .in_side  (fside_r),
    .out_valid(d1_v),
    .out_quot (d1_q),
    .out_rem  (d1_t),
    .out_side (d1_side)
  );

  // step count modulo spacing or comet cycle
  logic [32:0] d3_num;
  d3_side_t    d3_in_side, d3_side;
  logic        d3_v;
  logic [8:0]  d3_rem;

  assign d3_num = (mode_r == MODE_CHASE) ? 33'(d1_q) + 33'(d1_side.idx) : 33'(d1_q);
  assign d3_in_side = '{active: d1_side.active, rel: d1_side.rel, t: d1_t};

  lsepg_div #(.NW(33), .DW(9), .QW(33), .SW($bits(d3_side_t))) u_div_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (d1_v),
    .in_num   (d3_num),
    .in_den   (cmod),
    .in_side  (d3_in_side),
    .out_valid(d3_v),
    .out_quot (),
    .out_rem  (d3_rem),
    .out_side (d3_side)
  );

  // fraction of the period for fade and breathe
  logic [23:0] d2_num;
  d2_side_t    d2_in_side, d2_side;
  logic        d2_v;
  logic [7:0]  d2_q;

  assign d2_num = (mode_r == MODE_FADE) ? 24'({d3_side.t, 8'd0} - {8'd0, d3_side.t})
                                        : {d3_side.t, 8'd0};
  assign d2_in_side = '{active: d3_side.active, rel: d3_side.rel, rem: d3_rem};

  lsepg_div #(.NW(24), .DW(16), .QW(8), .SW($bits(d2_side_t))) u_div_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (d3_v),
    .in_num   (d2_num),
    .in_den   (per),
    .in_side  (d2_in_side),
    .out_valid(d2_v),
    .out_quot (d2_q),
    .out_rem  (),
    .out_side (d2_side)
  );

  // colour stages
  eff_cfg_t ecfg;
  assign ecfg = '{mode: mode_r, base: base_r, params: params_r, mn: mn_r, len: len};

  lsepg_effect u_effect (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cfg      (ecfg),
    .in_valid (d2_v),
    .in_frac  (d2_q),
    .in_side  (d2_side),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
